>>> rtl/rgbnv_pkg.sv
package rgbnv_pkg;

  localparam int unsigned MaxLineWidth = 2048;

  localparam int unsigned PixW  = 8;
  localparam int unsigned SumW  = PixW + 1;
  localparam int unsigned CfgW  = 12;
  localparam int unsigned ProdW = 16;

  localparam logic [CfgW-1:0] LineWidthReset = 12'd1920;

  // BT.601 limited range, 8.8 fixed point
  localparam logic [ProdW-1:0] CoefYR   = 16'd66;
  localparam logic [ProdW-1:0] CoefYG   = 16'd129;
  localparam logic [ProdW-1:0] CoefYB   = 16'd25;
  localparam logic [ProdW-1:0] OffsetY  = 16'd4224;   // 16 * 256 + 128
  localparam logic [ProdW-1:0] CoefUR   = 16'd38;     // subtracted
  localparam logic [ProdW-1:0] CoefUG   = 16'd74;     // subtracted
  localparam logic [ProdW-1:0] CoefUB   = 16'd112;
  localparam logic [ProdW-1:0] CoefVR   = 16'd112;
  localparam logic [ProdW-1:0] CoefVG   = 16'd94;     // subtracted
  localparam logic [ProdW-1:0] CoefVB   = 16'd18;     // subtracted
  localparam logic [ProdW-1:0] OffsetC  = 16'd32896;  // 128 * 256 + 128

  typedef struct packed {
    logic [SumW-1:0] blue;
    logic [SumW-1:0] green;
    logic [SumW-1:0] red;
  } pair_sum_t;

  typedef struct packed {
    logic [PixW-1:0] blue;
    logic [PixW-1:0] green;
    logic [PixW-1:0] red;
  } pixel_t;

endpackage

>>> rtl/rgb_to_nv12_converter_unit.sv
// RGB to NV12 converter (BT.601 limited range), one pixel per request.
// Input channel: in_valid_i / in_ready_o with red, green, blue and a
// frame_start flag that restarts the column and row-pair position.
// Output channel: out_valid_o / out_ready_i, one result per input pixel:
// luma of the pixel, row_end on the last pixel of a row, and on the odd
// columns of the second row of each pair chroma_valid with the U and V of
// the finished 2x2 block (U and V read 0 otherwise).
// Configuration: cfg_valid_i / cfg_ready_o writes line_width; write it only
// while no request is in flight. The low bit is ignored and the value is
// clamped to 2..MAX_LINE_WIDTH.
// An accepted pixel passes through stage 1, stage 2 and the output register;
// throughput is one pixel per cycle while the receiver keeps up, set by the
// single-port pair line store (one read or one write per odd-column pixel, registered read data).
// Reset clears the position, the row-pair flag, the left pixel and the stage
// valid flags and sets line_width to 1920; the line store is not cleared, so
// the second row of a pair must follow its first row.
// When the receiver stalls, the whole pipeline holds and in_ready_o drops
// once the output register is full; nothing is dropped.
module rgb_to_nv12_converter_unit #(
  parameter int unsigned MAX_LINE_WIDTH = rgbnv_pkg::MaxLineWidth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [rgbnv_pkg::PixW-1:0]  red_i,
  input  logic [rgbnv_pkg::PixW-1:0]  green_i,
  input  logic [rgbnv_pkg::PixW-1:0]  blue_i,
  input  logic                        frame_start_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [rgbnv_pkg::PixW-1:0]  luma_o,
  output logic                        chroma_valid_o,
  output logic [rgbnv_pkg::PixW-1:0]  u_value_o,
  output logic [rgbnv_pkg::PixW-1:0]  v_value_o,
  output logic                        row_end_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [rgbnv_pkg::CfgW-1:0]  cfg_line_width_i
);

  localparam int unsigned ColW   = $clog2(MAX_LINE_WIDTH);
  localparam int unsigned AddrW  = ColW - 1;
  localparam int unsigned Depth  = MAX_LINE_WIDTH / 2;
  localparam int unsigned WidthW = (ColW + 1 > rgbnv_pkg::CfgW) ? ColW + 1 : rgbnv_pkg::CfgW;
  localparam logic [WidthW-1:0] MaxWidth  = WidthW'(MAX_LINE_WIDTH);
  localparam logic [WidthW-1:0] MaxEven   = WidthW'(MAX_LINE_WIDTH & ~1);
  localparam logic [WidthW-1:0] MinWidth  = WidthW'(2);
  localparam int unsigned PixW = rgbnv_pkg::PixW;
  localparam int unsigned SumW = rgbnv_pkg::SumW;
  localparam int unsigned ProdW = rgbnv_pkg::ProdW;

  // configuration
  logic [rgbnv_pkg::CfgW-1:0] line_width_q;

  // position state
  logic [ColW-1:0]         col_q, col_d;
  logic                    second_q, second_d;
  rgbnv_pkg::pixel_t       left_q;

  // line store
  rgbnv_pkg::pair_sum_t    pair_store_q [Depth];
  rgbnv_pkg::pair_sum_t    rd_q;

  // stage 1
  logic                    s1_vld_q;
  logic [PixW-1:0]         s1_luma_q;
  logic                    s1_cv_q;
  logic                    s1_re_q;
  rgbnv_pkg::pair_sum_t    s1_sum_q;

  // stage 2
  logic                    s2_vld_q;
  logic [PixW-1:0]         s2_luma_q;
  logic                    s2_cv_q;
  logic                    s2_re_q;
  rgbnv_pkg::pixel_t       s2_avg_q;

  // output register
  logic                    out_vld_q;
  logic [PixW-1:0]         luma_q;
  logic                    cv_q;
  logic [PixW-1:0]         u_q;
  logic [PixW-1:0]         v_q;
  logic                    re_q;

  logic                    adv;
  logic                    accept;
  logic [ColW-1:0]         col_eff;
  logic                    second_eff;
  logic [WidthW-1:0]       width_even;
  logic [WidthW-1:0]       width_use;
  logic [WidthW-1:0]       last_col;
  logic                    row_end;
  logic                    odd_col;
  logic [AddrW-1:0]        store_addr;
  rgbnv_pkg::pair_sum_t    pair_sum;
  logic [ProdW-1:0]        luma_t;
  logic [SumW:0]           blk_r, blk_g, blk_b;
  logic [ProdW-1:0]        u_t, v_t;

  assign adv         = !out_vld_q || out_ready_i;
  assign in_ready_o  = adv;
  assign accept      = in_valid_i && adv;
  assign cfg_ready_o = 1'b1;

  // width in use: even, clamped to the store range
  always_comb begin
    width_even = WidthW'({line_width_q[rgbnv_pkg::CfgW-1:1], 1'b0});
    if (width_even < MinWidth) begin
      width_use = MinWidth;
    end else if (width_even > MaxWidth) begin
      width_use = MaxEven;
    end else begin
      width_use = width_even;
    end
    last_col = width_use - WidthW'(1);
  end

  always_comb begin
    col_eff    = frame_start_i ? '0 : col_q;
    second_eff = frame_start_i ? 1'b0 : second_q;
    odd_col    = col_eff[0];
    store_addr = col_eff[ColW-1:1];
    row_end    = WidthW'(col_eff) >= last_col;
    if (row_end) begin
      col_d    = '0;
      second_d = !second_eff;
    end else begin
      col_d    = col_eff + ColW'(1);
      second_d = second_eff;
    end
    pair_sum.red   = SumW'(red_i)   + SumW'(left_q.red);
    pair_sum.green = SumW'(green_i) + SumW'(left_q.green);
    pair_sum.blue  = SumW'(blue_i)  + SumW'(left_q.blue);
    luma_t = ProdW'(red_i) * rgbnv_pkg::CoefYR + ProdW'(green_i) * rgbnv_pkg::CoefYG
           + ProdW'(blue_i) * rgbnv_pkg::CoefYB + rgbnv_pkg::OffsetY;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= rgbnv_pkg::LineWidthReset;
    end else if (cfg_valid_i) begin
      line_width_q <= cfg_line_width_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      second_q <= 1'b0;
      left_q   <= '0;
    end else if (accept) begin
      col_q    <= col_d;
      second_q <= second_d;
      if (!odd_col) begin
        left_q <= '{blue: blue_i, green: green_i, red: red_i};
      end
    end
  end

  // single-port line store: write on first row, read on second row
  always_ff @(posedge clk_i) begin
    if (accept && odd_col) begin
      if (!second_eff) begin
        pair_store_q[store_addr] <= pair_sum;
      end else begin
        rd_q <= pair_store_q[store_addr];
      end
    end
  end

  // stage 1
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_luma_q <= luma_t[ProdW-1:PixW];
      s1_cv_q   <= odd_col && second_eff;
      s1_re_q   <= row_end;
      s1_sum_q  <= pair_sum;
    end
  end

  // stage 2: block average
  always_comb begin
    blk_r = (SumW+1)'(s1_sum_q.red)   + (SumW+1)'(rd_q.red);
    blk_g = (SumW+1)'(s1_sum_q.green) + (SumW+1)'(rd_q.green);
    blk_b = (SumW+1)'(s1_sum_q.blue)  + (SumW+1)'(rd_q.blue);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (adv) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_vld_q) begin
      s2_luma_q      <= s1_luma_q;
      s2_cv_q        <= s1_cv_q;
      s2_re_q        <= s1_re_q;
      s2_avg_q.red   <= blk_r[SumW:2];
      s2_avg_q.green <= blk_g[SumW:2];
      s2_avg_q.blue  <= blk_b[SumW:2];
    end
  end

  // stage 3: chroma; sums stay within 16 bits, so wrap-around subtraction is exact
  always_comb begin
    u_t = ProdW'(s2_avg_q.blue) * rgbnv_pkg::CoefUB + rgbnv_pkg::OffsetC
        - ProdW'(s2_avg_q.red) * rgbnv_pkg::CoefUR
        - ProdW'(s2_avg_q.green) * rgbnv_pkg::CoefUG;
    v_t = ProdW'(s2_avg_q.red) * rgbnv_pkg::CoefVR + rgbnv_pkg::OffsetC
        - ProdW'(s2_avg_q.green) * rgbnv_pkg::CoefVG
        - ProdW'(s2_avg_q.blue) * rgbnv_pkg::CoefVB;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s2_vld_q) begin
      luma_q <= s2_luma_q;
      cv_q   <= s2_cv_q;
      re_q   <= s2_re_q;
      u_q    <= s2_cv_q ? u_t[ProdW-1:PixW] : '0;
      v_q    <= s2_cv_q ? v_t[ProdW-1:PixW] : '0;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign luma_o         = luma_q;
  assign chroma_valid_o = cv_q;
  assign u_value_o      = u_q;
  assign v_value_o      = v_q;
  assign row_end_o      = re_q;

endmodule
